[src/assert_macros.svh]
// assertion macros shared by the checker files
// each macro samples on clk and is disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion clocked by clk, off during reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication form of the same
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication form
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/itoa_pkg.sv]
// shared types and constants for the integer to decimal text converter
// no dependencies
package itoa_pkg;

	localparam int ValueW    = 32;
	localparam int CharW     = 6;
	localparam int DigW      = 4;
	localparam int MaxDigits = 10;
	localparam int CntW      = $clog2(MaxDigits);
	localparam int ProdW     = 2 * ValueW;
	localparam int RecipShift = 35;
	localparam int QuotW     = ProdW - RecipShift;

	localparam logic [ValueW-1:0] Recip10  = 32'hCCCC_CCCD;
	localparam logic [CharW-1:0]  CharMinus = 6'd45;
	localparam logic [CharW-1:0]  CharZero  = 6'd48;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic div;
		logic step;
		logic sign_sel;
	} itoa_cmd_t;

	typedef struct packed {
		logic neg;
		logic q_zero;
		logic cnt_zero;
	} itoa_stat_t;

endpackage

[src/itoa_in_if.sv]
// input channel: one signed 32-bit value per transaction
// depends on itoa_pkg
interface itoa_in_if import itoa_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [ValueW-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

[src/itoa_out_if.sv]
// output channel: one ascii character and a last flag per transaction
// depends on itoa_pkg
interface itoa_out_if import itoa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CharW-1:0] character;
	logic             last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

[src/itoa_ctrl.sv]
// controller state machine: sequences load, divide-by-ten steps and character output
// depends on itoa_pkg
module itoa_ctrl import itoa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  itoa_stat_t stat,
	output itoa_cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (!stat.q_zero) begin
					state_nxt = ST_MUL;
				end else if (stat.neg) begin
					state_nxt = ST_SIGN;
				end else begin
					state_nxt = ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (out_ready) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_ready && stat.cnt_zero) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
			end
			ST_SIGN: begin
				out_valid    = 1'b1;
				cmd.sign_sel = 1'b1;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				cmd.step  = out_ready && !stat.cnt_zero;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[src/itoa_dp.sv]
// datapath: magnitude register, divide-by-ten by reciprocal multiply, digit store
// depends on itoa_pkg
module itoa_dp import itoa_pkg::*; (
	input  logic              clk,
	input  logic [ValueW-1:0] value,
	input  itoa_cmd_t         cmd,
	output itoa_stat_t        stat,
	output logic [CharW-1:0]  character,
	output logic              last
);

	logic              neg_q;
	logic [ValueW-1:0] mag_q;
	logic [ProdW-1:0]  prod_q;
	logic [CntW-1:0]   cnt_q;
	logic [DigW-1:0]   digits_q [MaxDigits];

	logic [QuotW-1:0]  quot;
	logic [ValueW-1:0] quot_x10;
	logic [ValueW-1:0] rem;

	assign quot     = prod_q[ProdW-1:RecipShift];
	assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
	assign rem      = mag_q - quot_x10;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[ValueW-1];
			mag_q <= value[ValueW-1] ? (ValueW'(0) - value) : value;
			cnt_q <= '0;
		end
		if (cmd.mul) begin
			prod_q <= ProdW'(mag_q) * ProdW'(Recip10);
		end
		if (cmd.div) begin
			digits_q[cnt_q] <= rem[DigW-1:0];
			mag_q           <= ValueW'(quot);
			if (quot != '0) begin
				cnt_q <= cnt_q + CntW'(1);
			end
		end
		if (cmd.step) begin
			cnt_q <= cnt_q - CntW'(1);
		end
	end

	assign stat.neg      = neg_q;
	assign stat.q_zero   = (quot == '0);
	assign stat.cnt_zero = (cnt_q == '0);

	assign character = cmd.sign_sel ? CharMinus : (CharZero + CharW'(digits_q[cnt_q]));
	assign last      = !cmd.sign_sel && (cnt_q == '0);

endmodule

[src/int_to_decimal_ascii.sv]
// top level: signed 32-bit integer to decimal ascii text, one character per transaction
// depends on itoa_pkg, itoa_in_if, itoa_out_if, itoa_ctrl, itoa_dp
//
// channel  dir  payload                 note
// din      in   value[31:0] signed      one value per transaction
// dout     out  character[5:0], last    one character per transaction, msb first
//
// a value with n digits is divided down digit by digit, then its characters go out one
// per cycle while dout is ready (n digits plus a leading '-' when negative)
// each digit passes through the shared divide-by-ten unit: multiply, then correct
// din is ready only when idle; a dout stall holds the character and freezes the machine
// arst_n clears the controller only; nothing is kept between values
module int_to_decimal_ascii import itoa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	itoa_in_if.sink       din,
	itoa_out_if.source    dout
);

	itoa_cmd_t  cmd;
	itoa_stat_t stat;

	itoa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	itoa_dp u_dp (
		.clk       (clk),
		.value     (din.value),
		.cmd       (cmd),
		.stat      (stat),
		.character (dout.character),
		.last      (dout.last)
	);

endmodule

[src/itoa_check.sv]
// port-level checker for the converter, attached by bind
// depends on itoa_pkg and assert_macros.svh
`include "assert_macros.svh"

module itoa_check import itoa_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [CharW-1:0] character,
	input logic             last
);

	logic           stall;
	logic           is_sign;
	logic           char_ok;
	logic [CharW:0] payload;

	assign stall   = out_valid && !out_ready;
	assign is_sign = (character == CharMinus);
	assign char_ok = is_sign || (character >= CharZero && character <= CharZero + CharW'(9));
	assign payload = {character, last};

	`ASSERT_NEXT(a_out_hold, stall, out_valid && $stable(payload), "stalled output changed")
	`ASSERT_IMPL(a_no_overlap, in_ready, !out_valid, "input taken while text still pending")
	`ASSERT_IMPL(a_char_range, out_valid, char_ok, "character out of range")
	`ASSERT_IMPL(a_sign_not_last, out_valid && is_sign, !last, "sign flagged as last")
	`ASSERT_IMPL(a_in_idle, in_valid && in_ready, !out_valid, "accept during output")

endmodule

bind int_to_decimal_ascii itoa_check u_itoa_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.character (dout.character),
	.last      (dout.last)
);

[test/itoa_checker.sv]
// checker for the integer to decimal text converter: watches both channels,
// predicts the character run of each accepted value and compares field by field
// depends on itoa_pkg, itoa_in_if, itoa_out_if
module itoa_checker import itoa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	itoa_in_if    din,
	itoa_out_if   dout,
	output int    chars_due,
	output int    mismatches
);

	localparam int Radix = 10;

	typedef struct packed {
		logic [CharW-1:0] character;
		logic             last;
	} ascii_char_t;

	ascii_char_t text_due[$];
	ascii_char_t due;
	int          errs = 0;

	assign mismatches = errs;

	function automatic void queue_decimal_text(input logic [ValueW-1:0] value);
		logic [ValueW-1:0] magnitude;
		logic [DigW-1:0]   digits [MaxDigits];
		int                ndigits;
		magnitude = value[ValueW-1] ? ValueW'(0 - value) : value;
		ndigits = 0;
		do begin
			digits[ndigits] = DigW'(magnitude % Radix);
			magnitude = magnitude / Radix;
			ndigits++;
		end while (magnitude != 0 && ndigits < MaxDigits);
		if (value[ValueW-1])
			text_due.push_back('{character: CharMinus, last: 1'b0});
		for (int i = ndigits - 1; i >= 0; i--)
			text_due.push_back('{character: CharW'(CharZero + digits[i]), last: (i == 0)});
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			chars_due <= 0;
		end else begin
			if (dout.valid && dout.ready) begin
				if (text_due.size() == 0) begin
					$display("%0t: unexpected character %0d last %0b", $time,
						dout.character, dout.last);
					errs++;
				end else begin
					due = text_due.pop_front();
					if (dout.character !== due.character) begin
						$display("%0t: character expected %0d actual %0d", $time,
							due.character, dout.character);
						errs++;
					end
					if (dout.last !== due.last) begin
						$display("%0t: last expected %0b actual %0b", $time,
							due.last, dout.last);
						errs++;
					end
				end
			end
			if (din.valid && din.ready)
				queue_decimal_text(din.value);
			chars_due <= text_due.size();
		end
	end

endmodule

[test/int_to_decimal_ascii_tb.sv]
// testbench top for int_to_decimal_ascii: drives values with random gaps,
// stalls the character channel at random and gives the verdict
// depends on itoa_pkg, itoa_in_if, itoa_out_if, itoa_checker and the block
module int_to_decimal_ascii_tb;
	import itoa_pkg::*;

	localparam int MaxGap     = 11;
	localparam int HoldCycles = 300;
	localparam int StallLimit = 5000;
	localparam int Chunks     = 10;
	localparam int ChunkItems = 43;
	localparam int Settle     = 40;

	logic clk;
	logic arst_n;
	logic steady;
	int   holds_asked;
	int   holds_done;
	int   quiet_cycles;
	int   chars_due;
	int   mismatches;

	itoa_in_if  din_if();
	itoa_out_if dout_if();

	int_to_decimal_ascii dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	itoa_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din_if),
		.dout       (dout_if),
		.chars_due  (chars_due),
		.mismatches (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [ValueW-1:0] draw_value();
		int     kind;
		int     ndigits;
		longint lo;
		longint hi;
		longint mag;
		logic   neg;
		kind = $urandom_range(0, 4);
		neg = 1'($urandom_range(0, 1));
		lo = 1;
		case (kind)
			0: return $urandom();
			1, 2: begin
				ndigits = $urandom_range(1, MaxDigits);
				repeat (ndigits - 1) lo = lo * 10;
				hi = lo * 10 - 1;
				if (hi > 64'sd2147483647)
					hi = neg ? 64'sd2147483648 : 64'sd2147483647;
				mag = lo + longint'($urandom) % (hi - lo + 1);
			end
			3: begin
				repeat ($urandom_range(0, MaxDigits - 1)) lo = lo * 10;
				mag = lo + $urandom_range(0, 2) - 1;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h0000_0000;
					1: return 32'h8000_0000;
					2: return 32'h7FFF_FFFF;
					default: return 32'hFFFF_FFFF;
				endcase
			end
		endcase
		return ValueW'(neg ? -mag : mag);
	endfunction

	task automatic offer_value(input logic [ValueW-1:0] v);
		int gap;
		gap = steady ? 0 : $urandom_range(0, MaxGap);
		if (gap > 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.value <= v;
		do @(posedge clk); while (!din_if.ready);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (chars_due != 0);
	endtask

	// receiver: random stall per character, long hold when asked
	initial begin
		int stall;
		dout_if.ready <= 1'b0;
		holds_done = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (holds_done != holds_asked) begin
				dout_if.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				holds_done++;
			end else begin
				stall = steady ? 0 : $urandom_range(0, MaxGap);
				if (stall > 0) begin
					dout_if.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			dout_if.ready <= 1'b1;
			do @(posedge clk); while (!dout_if.valid);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == StallLimit) begin
			$display("%0t: no transaction for %0d cycles", $time, StallLimit);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int corner[];
		corner = '{0, 1, -1, 9, 10, -9, -10, 99, 100, -100, 2147483647,
			32'sh8000_0000, -2147483647, 1000000000, 999999999, -1000000000,
			123456789, -987654321, 32'sh5555_5555, 32'shAAAA_AAAA, 1999999999};
		arst_n       <= 1'b0;
		din_if.valid <= 1'b0;
		din_if.value <= '0;
		steady       <= 1'b0;
		holds_asked  <= 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner[i])
			offer_value(ValueW'(corner[i]));

		// pause the sender until every character is out
		din_if.valid <= 1'b0;
		wait_drained();

		for (int c = 0; c < Chunks; c++) begin
			steady <= ($urandom_range(0, 3) == 0);
			if (c == 3)
				holds_asked <= holds_asked + 1;
			for (int n = 0; n < ChunkItems; n++)
				offer_value(draw_value());
			if (c == 6) begin
				din_if.valid <= 1'b0;
				wait_drained();
			end
		end

		din_if.valid <= 1'b0;
		wait_drained();
		repeat (Settle) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
